// ===== hw/rtl/glzwd_pkg.sv =====
package glzwd_pkg;

  localparam int CODE_W = 12;
  localparam int NFE_W = CODE_W + 1;
  localparam int PIX_W = 8;
  localparam int CW_W = 4;
  localparam int SIZE_W = 4;
  localparam int STAT_W = 2;

  localparam int TABLE_ENTRIES_DEF = 4096;
  localparam int MAX_CODE_WIDTH_DEF = 12;
  localparam logic [SIZE_W-1:0] MIN_SIZE_RESET = 4'd8;
  localparam logic [SIZE_W-1:0] MIN_SIZE_LO = 4'd2;
  localparam logic [SIZE_W-1:0] MIN_SIZE_HI = 4'd8;

  localparam logic [STAT_W-1:0] ST_OK = 2'd0;
  localparam logic [STAT_W-1:0] ST_END = 2'd1;
  localparam logic [STAT_W-1:0] ST_CORRUPT = 2'd2;
  localparam logic [STAT_W-1:0] ST_REFUSED = 2'd3;

  localparam logic [1:0] PH_NONE = 2'd0;
  localparam logic [1:0] PH_ROOT = 2'd1;
  localparam logic [1:0] PH_LINK = 2'd2;

  localparam logic MODE_SUBMIT = 1'b0;
  localparam logic MODE_PULL = 1'b1;

  typedef struct packed {
    logic mode;
    logic [CODE_W-1:0] code;
  } in_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic pixel_valid;
    logic last_of_string;
    logic [CW_W-1:0] code_width;
    logic [STAT_W-1:0] status;
  } out_t;

  typedef struct packed {
    logic accept;
    logic restart;
    logic halt_end;
    logic halt_bad;
    logic refuse;
    logic first_lit;
    logic add;
    logic walk_step;
    logic walk_next;
    logic walk_done;
    logic set_prev;
    logic pull_root;
    logic pull_out;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic mode;
    logic pending;
    logic phase_link;
    logic halted;
    logic first_exp;
    logic is_clear;
    logic is_end;
    logic lit_ok;
    logic code_bad;
    logic code_kwk;
    logic c_ge_first;
    logic c_ge_clear;
    logic pfx_ge_nxt;
  } sts_t;

  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v);
    logic [SIZE_W-1:0] r;
    r = v;
    if (v < MIN_SIZE_LO) r = MIN_SIZE_LO;
    if (v > MIN_SIZE_HI) r = MIN_SIZE_HI;
    return r;
  endfunction

endpackage

// ===== hw/rtl/glzwd_ram.sv =====
module glzwd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/glzwd_ctrl.sv =====
module glzwd_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  glzwd_pkg::sts_t sts_i,
  output glzwd_pkg::cmd_t cmd_o,
  output logic            busy_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_WALK = 3'd2;
  localparam logic [2:0] S_WWAIT = 3'd3;
  localparam logic [2:0] S_POST = 3'd4;

  logic [2:0] state_q, state_d;
  logic kwk_q, kwk_d;
  glzwd_pkg::cmd_t cmd;

  always_comb begin
    cmd = '0;
    state_d = state_q;
    kwk_d = kwk_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd.accept = 1'b1;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_IDLE;
        cmd.finish = 1'b1;
        if (sts_i.mode == glzwd_pkg::MODE_PULL) begin
          if (!sts_i.pending) cmd.refuse = 1'b1;
          else if (sts_i.phase_link) cmd.pull_out = 1'b1;
          else cmd.pull_root = 1'b1;
        end else if (sts_i.halted || sts_i.pending) begin
          cmd.refuse = 1'b1;
        end else if (sts_i.is_clear) begin
          cmd.restart = 1'b1;
        end else if (sts_i.is_end) begin
          cmd.halt_end = 1'b1;
        end else if (sts_i.first_exp) begin
          if (sts_i.lit_ok) cmd.first_lit = 1'b1;
          else cmd.halt_bad = 1'b1;
        end else if (sts_i.code_bad) begin
          cmd.halt_bad = 1'b1;
        end else begin
          // A code one past the table builds its own entry before the walk.
          cmd.finish = 1'b0;
          cmd.add = sts_i.code_kwk;
          kwk_d = sts_i.code_kwk;
          state_d = S_WALK;
        end
      end
      S_WALK: begin
        if (sts_i.c_ge_first) begin
          cmd.walk_step = 1'b1;
          state_d = S_WWAIT;
        end else if (sts_i.c_ge_clear) begin
          cmd.halt_bad = 1'b1;
          cmd.finish = 1'b1;
          state_d = S_IDLE;
        end else begin
          cmd.walk_done = 1'b1;
          state_d = S_POST;
        end
      end
      S_WWAIT: begin
        if (sts_i.pfx_ge_nxt) begin
          cmd.halt_bad = 1'b1;
          cmd.finish = 1'b1;
          state_d = S_IDLE;
        end else begin
          cmd.walk_next = 1'b1;
          state_d = S_WALK;
        end
      end
      S_POST: begin
        cmd.add = !kwk_q;
        cmd.set_prev = 1'b1;
        cmd.finish = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      kwk_q <= 1'b0;
    end else begin
      state_q <= state_d;
      kwk_q <= kwk_d;
    end
  end

  assign cmd_o = cmd;
  assign busy_o = (state_q != S_IDLE);

endmodule

// ===== hw/rtl/glzwd_dp.sv =====
module glzwd_dp #(
  parameter int TABLE_ENTRIES = glzwd_pkg::TABLE_ENTRIES_DEF,
  parameter int MAX_CODE_WIDTH = glzwd_pkg::MAX_CODE_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  glzwd_pkg::in_t                  in_i,
  input  logic                            cfg_we_i,
  input  logic [glzwd_pkg::SIZE_W-1:0]    cfg_wdata_i,
  input  glzwd_pkg::cmd_t                 cmd_i,
  output glzwd_pkg::sts_t                 sts_o,
  output logic                            done_o,
  output glzwd_pkg::out_t                 res_o
);

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int CW = glzwd_pkg::CODE_W;
  localparam int NW = glzwd_pkg::NFE_W;

  logic [glzwd_pkg::SIZE_W-1:0] size_q;
  logic [NW-1:0] nfe_q;
  logic [glzwd_pkg::CW_W-1:0] cw_q;
  logic [CW-1:0] prev_q, cursor_q, code_q, c_q, nxt_q;
  logic [1:0] phase_q;
  logic [glzwd_pkg::PIX_W-1:0] root_q, pixel_q;
  logic first_q, halted_q, mode_q, valid_q, last_q, done_q;
  logic [glzwd_pkg::STAT_W-1:0] stat_q;

  logic [CW-1:0] pfx_rdata, fwd_rdata;
  logic [glzwd_pkg::PIX_W-1:0] sfx_rdata;

  logic [glzwd_pkg::SIZE_W-1:0] s_cur, s_rst;
  logic [CW-1:0] clear_w, first_w;
  logic [NW-1:0] nfe_rst, nfe_inc, grow_at;
  logic [glzwd_pkg::CW_W-1:0] cw_rst;
  logic do_restart, table_room, add_we;

  assign s_cur = glzwd_pkg::eff_size(size_q);
  assign s_rst = glzwd_pkg::eff_size(cfg_we_i ? cfg_wdata_i : size_q);
  assign clear_w = CW'(1) << s_cur;
  assign first_w = clear_w + CW'(2);
  assign nfe_rst = (NW'(1) << s_rst) + NW'(2);
  assign cw_rst = (s_rst + 4'd1 > 4'(MAX_CODE_WIDTH)) ? 4'(MAX_CODE_WIDTH) : s_rst + 4'd1;
  assign do_restart = cmd_i.restart | cfg_we_i;
  assign table_room = (nfe_q < NW'(TABLE_ENTRIES));
  assign add_we = cmd_i.add & table_room;
  assign nfe_inc = nfe_q + NW'(1);
  assign grow_at = NW'(1) << cw_q;

  glzwd_ram #(.WIDTH(CW), .DEPTH(TABLE_ENTRIES)) u_prefix (
    .clk_i   (clk_i),
    .we_i    (add_we),
    .waddr_i (nfe_q[AW-1:0]),
    .wdata_i (prev_q),
    .raddr_i (c_q[AW-1:0]),
    .rdata_o (pfx_rdata)
  );

  glzwd_ram #(.WIDTH(glzwd_pkg::PIX_W), .DEPTH(TABLE_ENTRIES)) u_suffix (
    .clk_i   (clk_i),
    .we_i    (add_we),
    .waddr_i (nfe_q[AW-1:0]),
    .wdata_i (root_q),
    .raddr_i (cursor_q[AW-1:0]),
    .rdata_o (sfx_rdata)
  );

  glzwd_ram #(.WIDTH(CW), .DEPTH(TABLE_ENTRIES)) u_fwd (
    .clk_i   (clk_i),
    .we_i    (cmd_i.walk_step),
    .waddr_i (c_q[AW-1:0]),
    .wdata_i (nxt_q),
    .raddr_i (cursor_q[AW-1:0]),
    .rdata_o (fwd_rdata)
  );

  always_comb begin
    sts_o.mode = mode_q;
    sts_o.pending = (phase_q != glzwd_pkg::PH_NONE);
    sts_o.phase_link = (phase_q == glzwd_pkg::PH_LINK);
    sts_o.halted = halted_q;
    sts_o.first_exp = first_q;
    sts_o.is_clear = (code_q == clear_w);
    sts_o.is_end = (code_q == clear_w + CW'(1));
    sts_o.lit_ok = (code_q < clear_w);
    sts_o.code_bad = ({1'b0, code_q} >= NW'(TABLE_ENTRIES)) || ({1'b0, code_q} > nfe_q);
    sts_o.code_kwk = ({1'b0, code_q} == nfe_q);
    sts_o.c_ge_first = (c_q >= first_w);
    sts_o.c_ge_clear = (c_q >= clear_w);
    sts_o.pfx_ge_nxt = (pfx_rdata >= nxt_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= glzwd_pkg::MIN_SIZE_RESET;
      nfe_q <= (NW'(1) << glzwd_pkg::MIN_SIZE_RESET) + NW'(2);
      cw_q <= glzwd_pkg::MIN_SIZE_RESET + 4'd1;
      prev_q <= '0;
      first_q <= 1'b1;
      cursor_q <= '0;
      phase_q <= glzwd_pkg::PH_NONE;
      root_q <= '0;
      halted_q <= 1'b0;
      mode_q <= 1'b0;
      code_q <= '0;
      c_q <= '0;
      nxt_q <= '0;
      pixel_q <= '0;
      valid_q <= 1'b0;
      last_q <= 1'b0;
      stat_q <= glzwd_pkg::ST_OK;
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.finish;
      if (cfg_we_i) size_q <= cfg_wdata_i;
      if (cmd_i.accept) begin
        mode_q <= in_i.mode;
        code_q <= in_i.code;
        c_q <= in_i.code;
        nxt_q <= '0;
        pixel_q <= '0;
        valid_q <= 1'b0;
        last_q <= 1'b0;
        stat_q <= glzwd_pkg::ST_OK;
      end
      if (do_restart) begin
        nfe_q <= nfe_rst;
        cw_q <= cw_rst;
        first_q <= 1'b1;
        phase_q <= glzwd_pkg::PH_NONE;
        cursor_q <= '0;
        halted_q <= 1'b0;
      end
      if (cmd_i.refuse) stat_q <= glzwd_pkg::ST_REFUSED;
      if (cmd_i.halt_end) begin
        halted_q <= 1'b1;
        stat_q <= glzwd_pkg::ST_END;
      end
      if (cmd_i.halt_bad) begin
        halted_q <= 1'b1;
        stat_q <= glzwd_pkg::ST_CORRUPT;
        phase_q <= glzwd_pkg::PH_NONE;
      end
      if (cmd_i.first_lit) begin
        root_q <= code_q[glzwd_pkg::PIX_W-1:0];
        cursor_q <= '0;
        phase_q <= glzwd_pkg::PH_ROOT;
        prev_q <= code_q;
        first_q <= 1'b0;
      end
      if (add_we) begin
        nfe_q <= nfe_inc;
        if (nfe_inc == grow_at && cw_q < 4'(MAX_CODE_WIDTH)) cw_q <= cw_q + 4'd1;
      end
      if (cmd_i.walk_step) nxt_q <= c_q;
      if (cmd_i.walk_next) c_q <= pfx_rdata;
      if (cmd_i.walk_done) begin
        root_q <= c_q[glzwd_pkg::PIX_W-1:0];
        cursor_q <= nxt_q;
        phase_q <= glzwd_pkg::PH_ROOT;
      end
      if (cmd_i.set_prev) prev_q <= code_q;
      if (cmd_i.pull_root) begin
        pixel_q <= root_q;
        valid_q <= 1'b1;
        if (cursor_q == '0) begin
          last_q <= 1'b1;
          phase_q <= glzwd_pkg::PH_NONE;
        end else begin
          phase_q <= glzwd_pkg::PH_LINK;
        end
      end
      if (cmd_i.pull_out) begin
        pixel_q <= sfx_rdata;
        valid_q <= 1'b1;
        cursor_q <= fwd_rdata;
        if (fwd_rdata == '0) begin
          last_q <= 1'b1;
          phase_q <= glzwd_pkg::PH_NONE;
        end
      end
    end
  end

  assign done_o = done_q;
  assign res_o.pixel = pixel_q;
  assign res_o.pixel_valid = valid_q;
  assign res_o.last_of_string = last_q;
  assign res_o.code_width = cw_q;
  assign res_o.status = stat_q;

endmodule

// ===== hw/rtl/gif_lzw_code_decoder_top.sv =====
// GIF LZW code decoder. Raise start for one cycle while busy is low to hand
// in a beat: mode 0 submits one unpacked code, mode 1 pulls the next pixel of
// the pending string. Every beat yields exactly one result, shown on res_o
// for the single cycle in which done_o is high; the receiver cannot stall it,
// so it must take the result in that cycle. Pulls and clear, end, literal
// and refused codes need no chain walk. A table code walks its chain of
// table entries, reading the prefix memory once per entry, and each read
// is registered. The next start may come in the cycle that done_o is high.
// The width the unpacker must use for the next code is code_width in each
// result. Writing min_code_size restarts the decoder as a clear code does;
// write it only while busy is low. Table memories hold no reset state and
// need no clearing pass.
module gif_lzw_code_decoder_top #(
  parameter int TABLE_ENTRIES = glzwd_pkg::TABLE_ENTRIES_DEF,
  parameter int MAX_CODE_WIDTH = glzwd_pkg::MAX_CODE_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  glzwd_pkg::in_t               in_i,
  input  logic                         cfg_we_i,
  input  logic [glzwd_pkg::SIZE_W-1:0] cfg_wdata_i,
  output logic                         done_o,
  output glzwd_pkg::out_t              res_o
);

  glzwd_pkg::cmd_t cmd;
  glzwd_pkg::sts_t sts;

  // The controller sequences decode, chain walk and pulls.
  glzwd_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  // The datapath holds the tables, the decoder state and the result register.
  glzwd_dp #(
    .TABLE_ENTRIES  (TABLE_ENTRIES),
    .MAX_CODE_WIDTH (MAX_CODE_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .done_o      (done_o),
    .res_o       (res_o)
  );

endmodule

// ===== tb/sv/tb_gif_lzw_code_decoder_top.sv =====
`timescale 1ns / 100ps

// Testbench for the GIF LZW code decoder.
// A directed table goes first, then random traffic that is mostly well-formed:
// a string that a code leaves pending is mostly pulled out in full.
// A model of the decoder tables runs next to the block. Every accepted beat
// is turned into one expected result. Every done_o strobe is compared against
// the oldest expected result.
module tb_gif_lzw_code_decoder_top;

  localparam int NUM_RANDOM = 650;
  localparam int CYCLE_LIMIT = 20000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  glzwd_pkg::in_t in_i = '0;
  logic cfg_we_i = 1'b0;
  logic [glzwd_pkg::SIZE_W-1:0] cfg_wdata_i = '0;
  logic done_o;
  glzwd_pkg::out_t res_o;

  gif_lzw_code_decoder_top uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start(start),
    .busy(busy),
    .in_i(in_i),
    .cfg_we_i(cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .done_o(done_o),
    .res_o(res_o)
  );

  always #10 clk_i = ~clk_i;

  // Decoder model state. The table arrays are only read where a real
  // decode would have written them first, so they need no initial value.
  logic [glzwd_pkg::CODE_W-1:0] pfx_mem[4096];
  logic [glzwd_pkg::PIX_W-1:0] sfx_mem[4096];
  logic [glzwd_pkg::CODE_W-1:0] fwd_mem[4096];
  logic [glzwd_pkg::SIZE_W-1:0] size_reg;
  int unsigned free_code;
  int unsigned width_now;
  int unsigned prev_code;
  bit want_first;
  int unsigned cursor;
  logic [1:0] phase;
  int unsigned root_pix;
  bit stopped;

  glzwd_pkg::out_t pending_results[$];
  int errors = 0;
  int cycles = 0;
  int n_pixels = 0;
  int n_bad = 0;
  int n_cfg = 0;
  int n_kwk = 0;

  // A directed row may carry its own expected result.
  bit row_has_exp = 1'b0;
  glzwd_pkg::out_t row_exp;

  function automatic int unsigned clear_of();
    return 1 << glzwd_pkg::eff_size(size_reg);
  endfunction

  function void restart_tables();
    free_code = clear_of() + 2;
    width_now = glzwd_pkg::eff_size(size_reg) + 1;
    if (width_now > glzwd_pkg::MAX_CODE_WIDTH_DEF) width_now = glzwd_pkg::MAX_CODE_WIDTH_DEF;
    want_first = 1'b1;
    phase = glzwd_pkg::PH_NONE;
    cursor = 0;
    stopped = 1'b0;
  endfunction

  function void add_code(int unsigned suffix);
    if (free_code < glzwd_pkg::TABLE_ENTRIES_DEF) begin
      pfx_mem[free_code] = prev_code[glzwd_pkg::CODE_W-1:0];
      sfx_mem[free_code] = suffix[glzwd_pkg::PIX_W-1:0];
      free_code++;
      if (free_code == (1 << width_now) && width_now < glzwd_pkg::MAX_CODE_WIDTH_DEF) begin
        width_now++;
      end
    end
  endfunction

  // Follows the prefix chain down to its literal root and links every entry
  // forward so that pulls can hand the string out in order.
  function bit link_string(int unsigned c);
    int unsigned nxt;
    int unsigned first;
    nxt = 0;
    first = clear_of() + 2;
    while (c >= first) begin
      fwd_mem[c] = nxt[glzwd_pkg::CODE_W-1:0];
      nxt = c;
      c = pfx_mem[c];
      if (c >= nxt) return 1'b0;
    end
    if (c >= clear_of()) return 1'b0;
    root_pix = c;
    cursor = nxt;
    phase = glzwd_pkg::PH_ROOT;
    return 1'b1;
  endfunction

  function glzwd_pkg::out_t decode_beat(glzwd_pkg::in_t b);
    glzwd_pkg::out_t r;
    int unsigned code;
    r = '0;
    code = b.code;
    if (phase == 2'd3) phase = glzwd_pkg::PH_NONE;
    if (b.mode == glzwd_pkg::MODE_PULL) begin
      if (phase == glzwd_pkg::PH_NONE) begin
        r.status = glzwd_pkg::ST_REFUSED;
      end else if (phase == glzwd_pkg::PH_ROOT) begin
        r.pixel = root_pix[glzwd_pkg::PIX_W-1:0];
        r.pixel_valid = 1'b1;
        if (cursor == 0) begin
          r.last_of_string = 1'b1;
          phase = glzwd_pkg::PH_NONE;
        end else begin
          phase = glzwd_pkg::PH_LINK;
        end
      end else begin
        r.pixel = sfx_mem[cursor];
        r.pixel_valid = 1'b1;
        cursor = fwd_mem[cursor];
        if (cursor == 0) begin
          r.last_of_string = 1'b1;
          phase = glzwd_pkg::PH_NONE;
        end
      end
    end else if (stopped || phase != glzwd_pkg::PH_NONE) begin
      r.status = glzwd_pkg::ST_REFUSED;
    end else if (code == clear_of()) begin
      restart_tables();
    end else if (code == clear_of() + 1) begin
      stopped = 1'b1;
      r.status = glzwd_pkg::ST_END;
    end else if (want_first) begin
      if (code < clear_of()) begin
        root_pix = code;
        cursor = 0;
        phase = glzwd_pkg::PH_ROOT;
        prev_code = code;
        want_first = 1'b0;
      end else begin
        stopped = 1'b1;
        r.status = glzwd_pkg::ST_CORRUPT;
      end
    end else if (code >= glzwd_pkg::TABLE_ENTRIES_DEF || code > free_code) begin
      stopped = 1'b1;
      r.status = glzwd_pkg::ST_CORRUPT;
    end else if (code == free_code) begin
      // The string is the previous one plus its own first character.
      n_kwk++;
      add_code(root_pix);
      if (link_string(code)) begin
        prev_code = code;
      end else begin
        stopped = 1'b1;
        r.status = glzwd_pkg::ST_CORRUPT;
        phase = glzwd_pkg::PH_NONE;
      end
    end else if (link_string(code)) begin
      add_code(root_pix);
      prev_code = code;
    end else begin
      stopped = 1'b1;
      r.status = glzwd_pkg::ST_CORRUPT;
      phase = glzwd_pkg::PH_NONE;
    end
    r.code_width = width_now[glzwd_pkg::CW_W-1:0];
    return r;
  endfunction

  // Scoreboard and model update on the rising edge. The result check comes
  // before the push, since a new beat may be taken in the done cycle.
  always @(posedge clk_i) begin
    glzwd_pkg::out_t want;
    glzwd_pkg::out_t got;
    cycles <= cycles + 1;
    if (rst_ni) begin
      if (done_o) begin
        got = res_o;
        if (pending_results.size() == 0) begin
          $display("%0t: result with nothing expected: %p", $time, got);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (got.pixel !== want.pixel || got.pixel_valid !== want.pixel_valid ||
              got.last_of_string !== want.last_of_string ||
              got.code_width !== want.code_width || got.status !== want.status) begin
            $display("%0t: mismatch, expected %p, actual %p", $time, want, got);
            errors++;
          end
          if (got.pixel_valid === 1'b1) n_pixels++;
          if (got.status === glzwd_pkg::ST_CORRUPT) n_bad++;
        end
      end
      if (cfg_we_i) begin
        size_reg = cfg_wdata_i;
        restart_tables();
      end
      if (start && !busy) begin
        want = decode_beat(in_i);
        pending_results.push_back(row_has_exp ? row_exp : want);
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycles);
      $display("tb_gif_lzw_code_decoder_top failed");
      $finish;
    end
  end

  // Sender burst state: start stays high across beats inside a burst.
  int burst_left = 0;

  task automatic send_beat(input logic mode, input int unsigned code,
                           input bit has_exp, input glzwd_pkg::out_t exp_res);
    int gap;
    @(negedge clk_i);
    start <= 1'b1;
    in_i <= '{mode: mode, code: code[glzwd_pkg::CODE_W-1:0]};
    row_has_exp <= has_exp;
    row_exp <= exp_res;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk_i);
        start <= 1'b0;
        row_has_exp <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
  endtask

  // Register writes only land when the block is idle: drain, then pause.
  task automatic write_size(input logic [glzwd_pkg::SIZE_W-1:0] v);
    @(negedge clk_i);
    start <= 1'b0;
    row_has_exp <= 1'b0;
    while (pending_results.size() != 0 || busy) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    n_cfg++;
  endtask

  function automatic glzwd_pkg::out_t res_of(input logic [glzwd_pkg::PIX_W-1:0] pix,
                                             input logic vld, input logic lst,
                                             input int unsigned w,
                                             input logic [glzwd_pkg::STAT_W-1:0] st);
    glzwd_pkg::out_t r;
    r.pixel = pix;
    r.pixel_valid = vld;
    r.last_of_string = lst;
    r.code_width = w[glzwd_pkg::CW_W-1:0];
    r.status = st;
    return r;
  endfunction

  typedef struct {
    bit is_cfg;
    logic mode;
    int unsigned code;
    bit has_exp;
    glzwd_pkg::out_t exp_res;
  } row_t;

  row_t rows[$];

  task automatic add_row(input bit is_cfg, input logic mode, input int unsigned code,
                         input bit has_exp, input glzwd_pkg::out_t exp_res);
    row_t r;
    r.is_cfg = is_cfg;
    r.mode = mode;
    r.code = code;
    r.has_exp = has_exp;
    r.exp_res = exp_res;
    rows.push_back(r);
  endtask

  // Picks the next beat from the model state so that most codes are legal.
  task automatic random_beat();
    int unsigned clr;
    int unsigned pick;
    int unsigned code;
    clr = clear_of();
    pick = $urandom_range(0, 99);
    if (phase != glzwd_pkg::PH_NONE) begin
      if (pick < 4) send_beat(glzwd_pkg::MODE_SUBMIT, $urandom_range(0, 4095), 1'b0, '0);
      else send_beat(glzwd_pkg::MODE_PULL, $urandom_range(0, 4095), 1'b0, '0);
    end else begin
      if (pick < 3) begin
        send_beat(glzwd_pkg::MODE_PULL, $urandom_range(0, 4095), 1'b0, '0);
        return;
      end
      if (pick < 6) code = clr;
      else if (pick < 8) code = clr + 1;
      else if (pick < 11) begin
        // Above the next free entry, out of range or a non-literal first code; the end code near a full table.
        if (free_code < 4095) code = $urandom_range(free_code + 1, 4095);
        else code = clr + 1;
      end else if (want_first) code = $urandom_range(0, clr - 1);
      else if (pick < 22 && free_code < glzwd_pkg::TABLE_ENTRIES_DEF) code = free_code;
      else begin
        code = $urandom_range(0, free_code - 1);
        if (code == clr || code == clr + 1) code = $urandom_range(0, clr - 1);
      end
      send_beat(glzwd_pkg::MODE_SUBMIT, code, 1'b0, '0);
    end
  endtask

  initial begin
    int unsigned sizes[4];
    sizes = '{2, 8, 0, 15};
    size_reg = glzwd_pkg::MIN_SIZE_RESET;
    prev_code = 0;
    root_pix = 0;
    restart_tables();

    // Directed part, after reset with min_code_size 8: clear 256, end 257.
    add_row(0, glzwd_pkg::MODE_PULL, 0, 1, res_of(0, 0, 0, 9, glzwd_pkg::ST_REFUSED));
    add_row(0, glzwd_pkg::MODE_SUBMIT, 0, 1, res_of(0, 0, 0, 9, glzwd_pkg::ST_OK));
    add_row(0, glzwd_pkg::MODE_SUBMIT, 5, 1, res_of(0, 0, 0, 9, glzwd_pkg::ST_REFUSED));
    add_row(0, glzwd_pkg::MODE_PULL, 0, 1, res_of(0, 1, 1, 9, glzwd_pkg::ST_OK));
    add_row(0, glzwd_pkg::MODE_SUBMIT, 255, 0, '0);
    add_row(0, glzwd_pkg::MODE_PULL, 0, 1, res_of(255, 1, 1, 9, glzwd_pkg::ST_OK));
    // Code equal to the next free entry.
    add_row(0, glzwd_pkg::MODE_SUBMIT, 259, 0, '0);
    add_row(0, glzwd_pkg::MODE_PULL, 0, 0, '0);
    add_row(0, glzwd_pkg::MODE_PULL, 0, 0, '0);
    add_row(0, glzwd_pkg::MODE_SUBMIT, 258, 0, '0);
    add_row(0, glzwd_pkg::MODE_PULL, 0, 0, '0);
    add_row(0, glzwd_pkg::MODE_PULL, 4095, 0, '0);
    // Code far past the next free entry, then refusal while halted.
    add_row(0, glzwd_pkg::MODE_SUBMIT, 4095, 1, res_of(0, 0, 0, 9, glzwd_pkg::ST_CORRUPT));
    add_row(0, glzwd_pkg::MODE_SUBMIT, 256, 1, res_of(0, 0, 0, 9, glzwd_pkg::ST_REFUSED));
    add_row(0, glzwd_pkg::MODE_PULL, 0, 1, res_of(0, 0, 0, 9, glzwd_pkg::ST_REFUSED));
    // Smallest code size: clear 4, end 5, width 3.
    add_row(1, glzwd_pkg::MODE_SUBMIT, 2, 0, '0);
    add_row(0, glzwd_pkg::MODE_SUBMIT, 6, 1, res_of(0, 0, 0, 3, glzwd_pkg::ST_CORRUPT));
    add_row(1, glzwd_pkg::MODE_SUBMIT, 2, 0, '0);
    add_row(0, glzwd_pkg::MODE_SUBMIT, 3, 1, res_of(0, 0, 0, 3, glzwd_pkg::ST_OK));
    add_row(0, glzwd_pkg::MODE_PULL, 0, 1, res_of(3, 1, 1, 3, glzwd_pkg::ST_OK));
    add_row(0, glzwd_pkg::MODE_SUBMIT, 4, 1, res_of(0, 0, 0, 3, glzwd_pkg::ST_OK));
    add_row(0, glzwd_pkg::MODE_SUBMIT, 5, 1, res_of(0, 0, 0, 3, glzwd_pkg::ST_END));
    // Out of range register values act as the nearest legal size.
    add_row(1, glzwd_pkg::MODE_SUBMIT, 15, 0, '0);
    add_row(0, glzwd_pkg::MODE_SUBMIT, 257, 1, res_of(0, 0, 0, 9, glzwd_pkg::ST_END));
    add_row(1, glzwd_pkg::MODE_SUBMIT, 0, 0, '0);
    add_row(0, glzwd_pkg::MODE_SUBMIT, 4, 1, res_of(0, 0, 0, 3, glzwd_pkg::ST_OK));

    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (rows[i]) begin
      if (rows[i].is_cfg) write_size(rows[i].code[glzwd_pkg::SIZE_W-1:0]);
      else send_beat(rows[i].mode, rows[i].code, rows[i].has_exp, rows[i].exp_res);
    end

    // Random part, with a new code size now and then and after every halt.
    write_size(glzwd_pkg::MIN_SIZE_RESET);
    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (stopped || (n % 90 == 89)) begin
        if ($urandom_range(0, 2) == 0) begin
          write_size(glzwd_pkg::SIZE_W'(sizes[$urandom_range(0, 3)]));
        end else begin
          write_size(glzwd_pkg::SIZE_W'($urandom_range(0, 15)));
        end
      end
      random_beat();
    end

    @(negedge clk_i);
    start <= 1'b0;
    row_has_exp <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);

    $display("Covered %0d pixels, %0d corrupt results, %0d repeat-string codes,",
             n_pixels, n_bad, n_kwk);
    $display("and %0d code size writes.", n_cfg);
    if (errors == 0) begin
      $display("tb_gif_lzw_code_decoder_top passed");
    end else begin
      $display("tb_gif_lzw_code_decoder_top failed");
    end
    $finish;
  end

endmodule
